FILE: design/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and types for the min-tracking stack: default sizes,
// operation codes and result status codes.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef logic [1:0] op_code_t;
    typedef logic [1:0] status_t;

    localparam op_code_t OP_PUSH = 2'd0;
    localparam op_code_t OP_POP  = 2'd1;
    localparam op_code_t OP_READ = 2'd2;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_POP_EMPTY  = 2'd1;
    localparam status_t ST_PUSH_FULL  = 2'd2;

endpackage

FILE: design/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed values that also reports the minimum of its
// contents after every push, pop or read.
// ----------------------------------------------------------------------------
// The top entry and its running minimum sit in registers; the entries below
// it sit in a synchronous store whose read data is registered. A push, a
// read, a refused push, an ignored pop and a pop that empties the stack each
// load the result register directly. A pop that leaves entries behind first
// reads the store and waits: the new top has to come back from the store
// before the result can be formed. Results are held in an output register,
// so a new command transfer can be taken in the same cycle a finished result
// is handed off. An empty stack reports all ones for top and minimum.
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  mts_pkg::op_code_t                   operation,
    input  logic signed [VALUE_WIDTH-1:0]       push_value,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [VALUE_WIDTH-1:0]       top_value,
    output logic signed [VALUE_WIDTH-1:0]       min_value,
    output logic                                is_empty,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    depth_now,
    output mts_pkg::status_t                    status
);
    import mts_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // entries below the top
    logic signed [VALUE_WIDTH-1:0] val_mem [STACK_DEPTH];
    logic signed [VALUE_WIDTH-1:0] min_mem [STACK_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rd_val_reg;
    logic signed [VALUE_WIDTH-1:0] rd_min_reg;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic signed [VALUE_WIDTH-1:0] top_val_reg, top_val_next;
    logic signed [VALUE_WIDTH-1:0] top_min_reg, top_min_next;
    logic                          pop_wait_reg, pop_wait_next;

    logic                          rsp_valid_reg, rsp_valid_next;
    logic signed [VALUE_WIDTH-1:0] rsp_top_reg, rsp_top_next;
    logic signed [VALUE_WIDTH-1:0] rsp_min_reg, rsp_min_next;
    logic                          rsp_empty_reg, rsp_empty_next;
    logic [CNT_W-1:0]              rsp_depth_reg, rsp_depth_next;
    status_t                       rsp_status_reg, rsp_status_next;

    logic                          cmd_accept;
    logic                          rsp_free;
    logic                          wr_en;
    logic                          rd_en;
    logic [CNT_W-1:0]              cnt_m1;
    logic [CNT_W-1:0]              cnt_m2;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          is_full;
    logic                          load_rsp;

    assign rsp_free   = ~rsp_valid_reg | ~rsp_stall;
    assign cmd_stall  = pop_wait_reg | ~rsp_free;
    assign cmd_accept = cmd_valid & ~cmd_stall;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);
    assign wr_addr = cnt_m1[ADDR_W-1:0];
    assign rd_addr = cnt_m2[ADDR_W-1:0];
    assign is_full = (count_reg == CNT_W'(STACK_DEPTH));

    always_comb
    begin
        count_next      = count_reg;
        top_val_next    = top_val_reg;
        top_min_next    = top_min_reg;
        pop_wait_next   = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        load_rsp        = 1'b0;
        rsp_status_next = ST_OK;

        if (pop_wait_reg)
        begin
            // new top arrives from the store
            top_val_next = rd_val_reg;
            top_min_next = rd_min_reg;
            load_rsp     = 1'b1;
        end
        else if (cmd_accept)
        begin
            load_rsp = 1'b1;
            unique case (operation)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        rsp_status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        wr_en        = (count_reg != '0);
                        count_next   = count_reg + CNT_W'(1);
                        top_val_next = push_value;
                        if (count_reg == '0 || push_value < top_min_reg)
                        begin
                            top_min_next = push_value;
                        end
                    end
                end
                OP_POP:
                begin
                    if (count_reg == '0)
                    begin
                        rsp_status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        count_next = cnt_m1;
                        if (count_reg != CNT_W'(1))
                        begin
                            rd_en         = 1'b1;
                            pop_wait_next = 1'b1;
                            load_rsp      = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // read only; unused code behaves the same
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        rsp_depth_next = count_next;
        rsp_empty_next = (count_next == '0);
        if (count_next == '0)
        begin
            rsp_top_next = '1;
            rsp_min_next = '1;
        end
        else
        begin
            rsp_top_next = top_val_next;
            rsp_min_next = top_min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            val_mem[wr_addr] <= top_val_reg;
            min_mem[wr_addr] <= top_min_reg;
        end
        if (rd_en)
        begin
            rd_val_reg <= val_mem[rd_addr];
            rd_min_reg <= min_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pop_wait_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pop_wait_reg  <= pop_wait_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_min_reg <= top_min_next;
        if (load_rsp)
        begin
            rsp_top_reg    <= rsp_top_next;
            rsp_min_reg    <= rsp_min_next;
            rsp_empty_reg  <= rsp_empty_next;
            rsp_depth_reg  <= rsp_depth_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign top_value = rsp_top_reg;
    assign min_value = rsp_min_reg;
    assign is_empty  = rsp_empty_reg;
    assign depth_now = rsp_depth_reg;
    assign status    = rsp_status_reg;

    // a pop waiting on the store always finds the output slot free
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_wait_reg |-> !rsp_valid_reg)
        else $error("pop completion with output slot occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_empty_reg |-> rsp_depth_reg == '0 && rsp_top_reg == '1
            && rsp_min_reg == '1)
        else $error("empty result with stale top or depth");

    // a pop that leaves entries blocks the next command transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> cmd_stall && pop_wait_reg)
        else $error("pop read without wait cycle");

endmodule
